// File: design/pn_pkg.sv
// ----------------------------------------------------------------------------
// pn_pkg
// Shared constants and controller/datapath interface types for the path
// normalizer.
// ----------------------------------------------------------------------------
package pn_pkg;

	localparam int PATH_DEPTH    = 64;
	localparam int SEGMENT_DEPTH = 32;
	localparam int PATH_AW       = $clog2(PATH_DEPTH);
	localparam int SEG_AW        = $clog2(SEGMENT_DEPTH);
	localparam int CHAR_W        = 8;
	localparam int OUT_LEN_W     = 6;
	localparam int IN_TDATA_W    = ((CHAR_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W   = ((CHAR_W + OUT_LEN_W + 7) / 8) * 8;

	localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

	typedef struct packed {
		logic in_load;
		logic work_root;
		logic copy_start;
		logic seg_reset;
		logic store_rd;
		logic copy_wr;
		logic seg_push;
		logic sep_wr;
		logic idx_clear;
		logic trim_start;
		logic work_rd;
		logic rd_prev;
		logic idx_dec;
		logic trim_fin;
		logic seg_rd;
		logic app_wr;
		logic commit;
		logic emit_ld;
	} pn_cmd_t;

	typedef struct packed {
		logic c_slash;
		logic c_zero;
		logic first;
		logic final_flag;
		logic seg_full;
		logic seg_empty;
		logic seg_dot;
		logic seg_dotdot;
		logic copy_need;
		logic idx_at_end;
		logic idx_gt1;
		logic rd_slash;
		logic app_more;
		logic sep_ok;
		logic out_free;
	} pn_stat_t;

endpackage

// File: design/pn_dp.sv
// ----------------------------------------------------------------------------
// pn_dp
// Path normalizer datapath: committed path, working path and segment
// memories, length and index counters, and the output register.
// ----------------------------------------------------------------------------
module pn_dp import pn_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pn_cmd_t                cmd,
	output pn_stat_t               stat,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   s_tuser,
	input  logic                   s_tlast,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tlast
);

	localparam logic [PATH_AW-1:0] PATH_MAX = PATH_AW'(PATH_DEPTH - 1);
	localparam logic [SEG_AW-1:0]  SEG_MAX  = SEG_AW'(SEGMENT_DEPTH - 1);

	logic [CHAR_W-1:0] store_mem [PATH_DEPTH];
	logic [CHAR_W-1:0] work_mem  [PATH_DEPTH];
	logic [CHAR_W-1:0] seg_mem   [SEGMENT_DEPTH];

	logic [CHAR_W-1:0]    c_q;
	logic                 first_q;
	logic                 final_q;
	logic [CHAR_W-1:0]    seg0_q;
	logic [CHAR_W-1:0]    seg1_q;
	logic [PATH_AW-1:0]   work_len_q;
	logic [PATH_AW-1:0]   path_len_q;
	logic [SEG_AW-1:0]    seg_len_q;
	logic [PATH_AW-1:0]   idx_q;
	logic [CHAR_W-1:0]    store_rd_q;
	logic [CHAR_W-1:0]    work_rd_q;
	logic                 work_zero_q;
	logic [CHAR_W-1:0]    seg_rd_q;
	logic                 out_valid_q;
	logic [CHAR_W-1:0]    out_char_q;
	logic [OUT_LEN_W-1:0] out_len_q;
	logic                 out_last_q;

	logic [PATH_AW-1:0] work_raddr;
	logic [CHAR_W-1:0]  work_rdata;
	logic               work_we;
	logic [PATH_AW-1:0] work_waddr;
	logic [CHAR_W-1:0]  work_wdata;

	assign work_raddr = cmd.rd_prev ? idx_q - PATH_AW'(1) : idx_q;
	assign work_rdata = work_zero_q ? CH_SLASH : work_rd_q;

	always_comb begin
		work_we    = cmd.copy_wr | cmd.sep_wr | cmd.app_wr;
		work_waddr = work_len_q;
		work_wdata = CH_SLASH;
		if (cmd.copy_wr) begin
			work_waddr = idx_q;
			work_wdata = store_rd_q;
		end else if (cmd.app_wr) begin
			work_wdata = seg_rd_q;
		end
	end

	// memories and payload
	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			c_q     <= s_tdata[CHAR_W-1:0];
			first_q <= s_tuser;
			final_q <= s_tlast;
		end
		if (cmd.seg_push) begin
			seg_mem[seg_len_q] <= c_q;
			if (seg_len_q == SEG_AW'(0))
				seg0_q <= c_q;
			if (seg_len_q == SEG_AW'(1))
				seg1_q <= c_q;
		end
		if (cmd.seg_rd)
			seg_rd_q <= seg_mem[idx_q[SEG_AW-1:0]];
		if (cmd.store_rd)
			store_rd_q <= store_mem[idx_q];
		if (cmd.work_rd) begin
			work_rd_q   <= work_mem[work_raddr];
			work_zero_q <= (work_raddr == PATH_AW'(0));
		end
		if (work_we)
			work_mem[work_waddr] <= work_wdata;
		if (cmd.emit_ld) begin
			store_mem[idx_q] <= work_rdata;
			out_char_q       <= work_rdata;
			out_len_q        <= OUT_LEN_W'(path_len_q);
			out_last_q       <= stat.idx_at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_len_q  <= PATH_AW'(1);
			path_len_q  <= PATH_AW'(1);
			seg_len_q   <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.work_root)
				work_len_q <= PATH_AW'(1);
			else if (cmd.copy_start)
				work_len_q <= path_len_q;
			else if (cmd.sep_wr || cmd.app_wr)
				work_len_q <= work_len_q + PATH_AW'(1);
			else if (cmd.trim_fin)
				work_len_q <= stat.idx_gt1 ? idx_q - PATH_AW'(1) : PATH_AW'(1);

			if (cmd.commit)
				path_len_q <= work_len_q;

			if (cmd.seg_reset)
				seg_len_q <= '0;
			else if (cmd.seg_push)
				seg_len_q <= seg_len_q + SEG_AW'(1);

			if (cmd.copy_start)
				idx_q <= PATH_AW'(1);
			else if (cmd.idx_clear || cmd.commit)
				idx_q <= '0;
			else if (cmd.trim_start)
				idx_q <= work_len_q;
			else if (cmd.copy_wr || cmd.app_wr || cmd.emit_ld)
				idx_q <= idx_q + PATH_AW'(1);
			else if (cmd.idx_dec)
				idx_q <= idx_q - PATH_AW'(1);

			if (cmd.emit_ld)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		stat.c_slash    = (c_q == CH_SLASH);
		stat.c_zero     = (c_q == CH_NUL);
		stat.first      = first_q;
		stat.final_flag = final_q;
		stat.seg_full   = (seg_len_q == SEG_MAX);
		stat.seg_empty  = (seg_len_q == SEG_AW'(0));
		stat.seg_dot    = (seg_len_q == SEG_AW'(1)) && (seg0_q == CH_DOT);
		stat.seg_dotdot = (seg_len_q == SEG_AW'(2)) && (seg0_q == CH_DOT)
			&& (seg1_q == CH_DOT);
		stat.copy_need  = (path_len_q > PATH_AW'(1));
		stat.idx_at_end = (idx_q == path_len_q - PATH_AW'(1));
		stat.idx_gt1    = (idx_q > PATH_AW'(1));
		stat.rd_slash   = (work_rdata == CH_SLASH);
		stat.app_more   = (idx_q < PATH_AW'(seg_len_q)) && (work_len_q < PATH_MAX);
		stat.sep_ok     = (work_len_q != PATH_AW'(1)) && (work_len_q < PATH_MAX);
		stat.out_free   = !out_valid_q || m_tready;
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(OUT_TDATA_W - CHAR_W - OUT_LEN_W){1'b0}}, out_len_q, out_char_q};

endmodule

// File: design/pn_ctrl.sv
// ----------------------------------------------------------------------------
// pn_ctrl
// Path normalizer controller: sequences copy, segment close, append, trim
// and emission steps over the datapath.
// ----------------------------------------------------------------------------
module pn_ctrl import pn_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  pn_stat_t stat,
	output pn_cmd_t  cmd
);

	typedef enum logic [15:0] {
		ST_IDLE     = 16'h0001,
		ST_START    = 16'h0002,
		ST_COPY_RD  = 16'h0004,
		ST_COPY_WR  = 16'h0008,
		ST_CHAR     = 16'h0010,
		ST_CLOSE    = 16'h0020,
		ST_APP_RD   = 16'h0040,
		ST_APP_WR   = 16'h0080,
		ST_TRIM_RD  = 16'h0100,
		ST_TRIM_CK  = 16'h0200,
		ST_NAME_RD  = 16'h0400,
		ST_NAME_CK  = 16'h0800,
		ST_TRIM_FIN = 16'h1000,
		ST_SEG_END  = 16'h2000,
		ST_EMIT_RD  = 16'h4000,
		ST_EMIT_LD  = 16'h8000
	} pn_state_t;

	pn_state_t state_q;
	pn_state_t state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.in_load = 1'b1;
					state_d     = ST_START;
				end
			end
			ST_START: begin
				state_d = ST_CHAR;
				if (stat.first) begin
					cmd.seg_reset = 1'b1;
					if (stat.c_slash) begin
						cmd.work_root = 1'b1;
					end else begin
						cmd.copy_start = 1'b1;
						if (stat.copy_need)
							state_d = ST_COPY_RD;
					end
				end
			end
			ST_COPY_RD: begin
				cmd.store_rd = 1'b1;
				state_d      = ST_COPY_WR;
			end
			ST_COPY_WR: begin
				cmd.copy_wr = 1'b1;
				state_d     = stat.idx_at_end ? ST_CHAR : ST_COPY_RD;
			end
			ST_CHAR: begin
				if (stat.c_slash) begin
					state_d = ST_CLOSE;
				end else begin
					cmd.seg_push = !stat.c_zero && !stat.seg_full;
					state_d      = stat.final_flag ? ST_CLOSE : ST_IDLE;
				end
			end
			ST_CLOSE: begin
				if (stat.seg_empty || stat.seg_dot) begin
					state_d = ST_SEG_END;
				end else if (stat.seg_dotdot) begin
					cmd.trim_start = 1'b1;
					state_d        = ST_TRIM_RD;
				end else begin
					cmd.sep_wr    = stat.sep_ok;
					cmd.idx_clear = 1'b1;
					state_d       = ST_APP_RD;
				end
			end
			ST_APP_RD: begin
				if (stat.app_more) begin
					cmd.seg_rd = 1'b1;
					state_d    = ST_APP_WR;
				end else begin
					state_d = ST_SEG_END;
				end
			end
			ST_APP_WR: begin
				cmd.app_wr = 1'b1;
				state_d    = ST_APP_RD;
			end
			ST_TRIM_RD: begin
				if (stat.idx_gt1) begin
					cmd.work_rd = 1'b1;
					cmd.rd_prev = 1'b1;
					state_d     = ST_TRIM_CK;
				end else begin
					state_d = ST_TRIM_FIN;
				end
			end
			ST_TRIM_CK: begin
				cmd.idx_dec = 1'b1;
				state_d     = stat.rd_slash ? ST_TRIM_RD : ST_NAME_RD;
			end
			ST_NAME_RD: begin
				if (stat.idx_gt1) begin
					cmd.work_rd = 1'b1;
					cmd.rd_prev = 1'b1;
					state_d     = ST_NAME_CK;
				end else begin
					state_d = ST_TRIM_FIN;
				end
			end
			ST_NAME_CK: begin
				if (stat.rd_slash) begin
					state_d = ST_TRIM_FIN;
				end else begin
					cmd.idx_dec = 1'b1;
					state_d     = ST_NAME_RD;
				end
			end
			ST_TRIM_FIN: begin
				cmd.trim_fin = 1'b1;
				state_d      = ST_SEG_END;
			end
			ST_SEG_END: begin
				cmd.seg_reset = 1'b1;
				if (stat.final_flag) begin
					cmd.commit = 1'b1;
					state_d    = ST_EMIT_RD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT_RD: begin
				cmd.work_rd = 1'b1;
				state_d     = ST_EMIT_LD;
			end
			ST_EMIT_LD: begin
				if (stat.out_free) begin
					cmd.emit_ld = 1'b1;
					state_d     = stat.idx_at_end ? ST_IDLE : ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// File: design/path_normalizer_core.sv
// ----------------------------------------------------------------------------
// path_normalizer_core
// Streaming path canonicalizer. Bytes of a target path enter on the slave
// beat channel; s_tuser marks the first byte of a target and s_tlast its
// last byte. Relative targets resolve against the stored current path,
// which is "/" after reset. "." segments drop, ".." removes one component
// without going above the root, segments keep at most 31 bytes and the path
// saturates at 63 bytes. On the last byte the resolved path becomes the
// stored path and is sent on the master channel one byte per beat, with its
// total length on every beat and m_tlast on the final byte.
// A byte that only grows a segment is the least work; closing a segment on
// a slash or the last byte adds steps, more for an append or "..", plus a
// read and a write per appended byte and a read per byte read back by "..".
// A relative target start adds a read and a write per stored byte copied.
// The single read port of the working path and segment memories sets these.
// Each output byte is read back from the working path before it is loaded
// into the output register. Input is held off (s_tready low) while a beat is in
// work or the path is being sent; a stalled receiver holds the output
// register and the sequencer waits on it. Reset returns the stored path to
// "/", empties the segment and drops any pending output beat.
// ----------------------------------------------------------------------------
module path_normalizer_core import pn_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // [7:0] path_char
	input  logic                   s_tuser,  // [0] first_char
	input  logic                   s_tlast,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // [7:0] out_char, [13:8] out_length
	output logic                   m_tlast
);

	pn_cmd_t  cmd;
	pn_stat_t stat;

	pn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pn_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// File: tb/path_normalizer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_normalizer_core_tb
// Streams target paths into the path normalizer and checks every emitted
// beat against a behavioral path resolver kept in step with the accepted
// input beats. A short table of directed targets comes first, then random
// targets built from names, ".", "..", slash runs and noise, under changing
// sender and receiver back-pressure.
// ----------------------------------------------------------------------------
module path_normalizer_core_tb;
	import pn_pkg::*;

	localparam int NUM_DIR      = 24;
	localparam int RANDOM_ITEMS = 170;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 300;

	typedef struct packed {
		logic [CHAR_W-1:0]    ch;
		logic [OUT_LEN_W-1:0] len;
		logic                 is_last;
	} path_beat_t;

	typedef struct {
		logic [CHAR_W-1:0] ch;
		bit                is_first;
		bit                is_last;
		string             want;
	} dir_row_t;

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;   // [7:0] path_char
	logic                   s_tuser = 1'b0; // [0] first_char
	logic                   s_tlast = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;        // [7:0] out_char, [13:8] out_length
	logic                   m_tlast;

	path_beat_t expected_beats[$];
	int         errors = 0;
	int         cycle_count = 0;
	int         send_idle_pct = 8;
	int         recv_idle_pct = 56;
	int         rand_items = 0;

	logic [CHAR_W-1:0] cur_path [PATH_DEPTH];
	int                cur_len;
	logic [CHAR_W-1:0] work_buf [PATH_DEPTH];
	int                work_len;
	logic [CHAR_W-1:0] seg_buf [SEGMENT_DEPTH];
	int                seg_len;

	dir_row_t dir_table [NUM_DIR] = '{
		'{CH_SLASH, 1'b1, 1'b1, "/"},
		'{"a",      1'b0, 1'b1, "/a"},
		'{CH_DOT,   1'b1, 1'b1, "/a"},
		'{CH_DOT,   1'b1, 1'b0, ""},
		'{CH_DOT,   1'b0, 1'b1, "/"},
		'{CH_SLASH, 1'b1, 1'b0, ""},
		'{CH_NUL,   1'b0, 1'b0, ""},
		'{CH_DOT,   1'b0, 1'b0, ""},
		'{CH_DOT,   1'b0, 1'b0, ""},
		'{CH_SLASH, 1'b0, 1'b0, ""},
		'{CH_SLASH, 1'b0, 1'b0, ""},
		'{"q",      1'b0, 1'b1, "/q"},
		'{8'hFF,    1'b1, 1'b0, ""},
		'{8'h01,    1'b0, 1'b0, ""},
		'{8'h80,    1'b0, 1'b0, ""},
		'{CH_SLASH, 1'b0, 1'b1, ""},
		'{"z",      1'b1, 1'b0, ""},
		'{CH_NUL,   1'b1, 1'b1, ""},
		'{CH_SLASH, 1'b1, 1'b0, ""},
		'{CH_DOT,   1'b0, 1'b0, ""},
		'{CH_DOT,   1'b0, 1'b0, ""},
		'{CH_DOT,   1'b0, 1'b1, "/..."},
		'{8'h7F,    1'b0, 1'b1, ""},
		'{CH_SLASH, 1'b1, 1'b1, "/"}
	};

	path_normalizer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAILURE");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
	end

	task automatic flag_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		errors++;
	endtask

	always @(posedge clk) begin
		path_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_beats.size() == 0) begin
				flag_mismatch($sformatf("beat %h with nothing pending", m_tdata));
			end else begin
				want = expected_beats.pop_front();
				if (m_tdata[CHAR_W-1:0] !== want.ch)
					flag_mismatch($sformatf("out_char %h, expected %h",
						m_tdata[CHAR_W-1:0], want.ch));
				if (m_tdata[CHAR_W +: OUT_LEN_W] !== want.len)
					flag_mismatch($sformatf("out_length %0d, expected %0d",
						m_tdata[CHAR_W +: OUT_LEN_W], want.len));
				if (m_tlast !== want.is_last)
					flag_mismatch($sformatf("m_tlast %b, expected %b", m_tlast, want.is_last));
				if (m_tdata[OUT_TDATA_W-1:CHAR_W+OUT_LEN_W] !== '0)
					flag_mismatch($sformatf("padding bits set in %h", m_tdata));
			end
		end
	end

	// path resolver
	function automatic void drop_component();
		int n;
		n = work_len;
		while (n > 1 && work_buf[n-1] == CH_SLASH)
			n--;
		while (n > 1 && work_buf[n-1] != CH_SLASH)
			n--;
		if (n <= 1) begin
			work_buf[0] = CH_SLASH;
			work_len = 1;
		end else begin
			work_len = n - 1;
		end
	endfunction

	function automatic void add_segment();
		int i;
		if (!(work_len == 1 && work_buf[0] == CH_SLASH) && work_len + 1 < PATH_DEPTH) begin
			work_buf[work_len] = CH_SLASH;
			work_len++;
		end
		for (i = 0; i < seg_len && work_len + 1 < PATH_DEPTH; i++) begin
			work_buf[work_len] = seg_buf[i];
			work_len++;
		end
	endfunction

	function automatic void end_segment();
		if (seg_len == 0)
			return;
		if (seg_len == 2 && seg_buf[0] == CH_DOT && seg_buf[1] == CH_DOT)
			drop_component();
		else if (!(seg_len == 1 && seg_buf[0] == CH_DOT))
			add_segment();
		seg_len = 0;
	endfunction

	function automatic bit resolve_char(input logic [CHAR_W-1:0] c, input bit is_first,
			input bit is_last);
		if (is_first) begin
			if (c == CH_SLASH) begin
				work_buf[0] = CH_SLASH;
				work_len = 1;
			end else begin
				work_buf = cur_path;
				work_len = cur_len;
			end
			seg_len = 0;
		end
		if (c == CH_SLASH) begin
			end_segment();
		end else if (c != CH_NUL && seg_len + 1 < SEGMENT_DEPTH) begin
			seg_buf[seg_len] = c;
			seg_len++;
		end
		if (!is_last)
			return 1'b0;
		end_segment();
		cur_path = work_buf;
		cur_len = work_len;
		return 1'b1;
	endfunction

	task automatic put_char(input logic [CHAR_W-1:0] c, input bit is_first, input bit is_last,
			input string want);
		int k;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = c;
		s_tuser  = is_first;
		s_tlast  = is_last;
		do @(posedge clk); while (!s_tready);
		if (resolve_char(c, is_first, is_last)) begin
			if (want.len() != 0) begin
				for (k = 0; k < want.len(); k++)
					expected_beats.push_back('{ch: want[k], len: OUT_LEN_W'(want.len()),
						is_last: (k == want.len() - 1)});
			end else begin
				for (k = 0; k < cur_len; k++)
					expected_beats.push_back('{ch: cur_path[k], len: OUT_LEN_W'(cur_len),
						is_last: (k == cur_len - 1)});
			end
		end
		@(negedge clk);
	endtask

	function automatic logic [CHAR_W-1:0] name_char();
		logic [CHAR_W-1:0] c;
		if ($urandom_range(0, 1) == 0)
			c = CHAR_W'($urandom_range(8'h61, 8'h7A));
		else
			c = CHAR_W'($urandom_range(1, 255));
		if (c == CH_SLASH)
			c = "x";
		return c;
	endfunction

	task automatic send_target();
		logic [CHAR_W-1:0] tgt[$];
		int                nsegs;
		int                s;
		int                j;
		int                n;
		int                phase;
		bit                no_first;
		bit                no_final;
		phase = rand_items * 3 / RANDOM_ITEMS;
		send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 56 : 0;
		recv_idle_pct = (phase == 0) ? 56 : (phase == 1) ? 8 : 0;
		no_first = ($urandom_range(0, 9) == 0);
		no_final = ($urandom_range(0, 11) == 0);
		if ($urandom_range(0, 2) == 0)
			tgt.push_back(CH_SLASH);
		nsegs = $urandom_range(1, 4);
		for (s = 0; s < nsegs; s++) begin
			case ($urandom_range(0, 9))
				0: tgt.push_back(CH_DOT);
				1, 2: begin
					tgt.push_back(CH_DOT);
					tgt.push_back(CH_DOT);
				end
				3, 4: begin
					n = $urandom_range(25, 40);
					for (j = 0; j < n; j++)
						tgt.push_back(name_char());
				end
				5: begin
					n = $urandom_range(1, 3);
					for (j = 0; j < n; j++)
						tgt.push_back(CHAR_W'($urandom_range(0, 255)));
				end
				default: begin
					n = $urandom_range(1, 6);
					for (j = 0; j < n; j++)
						tgt.push_back(name_char());
				end
			endcase
			if (s < nsegs - 1 || $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 3);
				for (j = 0; j < n; j++)
					tgt.push_back(CH_SLASH);
			end
		end
		for (j = 0; j < tgt.size(); j++) begin
			put_char(tgt[j], (j == 0) && !no_first, (j == tgt.size() - 1) && !no_final, "");
			rand_items++;
		end
	endtask

	initial begin
		int r;
		foreach (cur_path[i])
			cur_path[i] = CH_NUL;
		cur_path[0] = CH_SLASH;
		cur_len = 1;
		work_buf = cur_path;
		work_len = 1;
		foreach (seg_buf[i])
			seg_buf[i] = CH_NUL;
		seg_len = 0;

		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		for (r = 0; r < NUM_DIR; r++)
			put_char(dir_table[r].ch, dir_table[r].is_first, dir_table[r].is_last,
				dir_table[r].want);

		while (rand_items < RANDOM_ITEMS)
			send_target();
		s_tvalid = 1'b0;

		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0 && expected_beats.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
